/* rtl/core/thc_pkg.sv */
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types, register indexes and helpers of the temperature and
// humidity compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package thc_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_TEMP_COEF_ONE      = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_TEMP_COEF_TWO      = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_TEMP_COEF_THREE    = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_HUM_COEF_ONE       = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM_COEF_TWO       = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_HUM_COEF_THREE     = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_HUM_COEF_FOUR_FIVE = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_HUM_COEF_SIX       = 4'd7;

  localparam logic [31:0] FINE_OFFSET   = 32'd76800;
  localparam logic [31:0] TEMP_ROUND    = 32'd128;
  localparam logic [31:0] HUM_A_ROUND   = 32'd16384;
  localparam logic [31:0] HUM_X3_BIAS   = 32'd32768;
  localparam logic [31:0] HUM_B_BIAS    = 32'd2097152;
  localparam logic [31:0] HUM_B_ROUND   = 32'd8192;
  localparam logic [31:0] HUM_MAX_Q22   = 32'd419430400;
  localparam logic [16:0] HUM_FIXED_MAX = 17'd102400;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [7:0]  c1;
    logic [15:0] c2;
    logic [7:0]  c3;
    logic [23:0] c45;
    logic [7:0]  c6;
  } thc_coef_t;

  // Fine temperature plus the humidity reading of the same sample.
  typedef struct packed {
    logic [31:0] fine;
    logic [15:0] hum;
  } thc_fine_t;

  // Humidity factors and the finished temperature.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b2;
    logic [31:0] temp;
  } thc_mid_t;

  // Arithmetic right shift on a 32-bit two's complement word.
  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = $signed(x);
    return 32'(s >>> n);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/temp_humidity_compensation.sv */
// ----------------------------------------------------------------------------
// temp_humidity_compensation
// Compensates raw temperature and humidity readings with calibration
// coefficients held in eight write-only registers.
// ----------------------------------------------------------------------------
// One sample pair in, one result out. The datapath is a ten-stage pipeline
// with at most one 32-bit multiplier between registers, so a transaction is
// accepted every cycle unless back-pressure stalls the pipeline. The
// accepting edge loads the first stage, and the result is taken from the
// output register when the output side is ready. Each stage carries a
// valid bit and loads only when it is empty or its successor moves, so
// back-pressure fills bubbles first and nothing is dropped or duplicated.
// All intermediates are 32-bit two's complement words that wrap; right
// shifts are arithmetic. Temperature comes out in 0.01 degC; humidity comes
// out as value/1024 %RH, clamped to 0..100 %. Write coefficients only while
// no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module temp_humidity_compensation
  import thc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // sample channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [19:0]         raw_temperature_i,
  input  wire logic [15:0]         raw_humidity_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [31:0]       temperature_centi_o,
  output logic [16:0]              humidity_fixed_o
);

  thc_coef_t   coef_q;
  logic        fine_valid, fine_ready, mid_valid, mid_ready;
  thc_fine_t   fine_data;
  thc_mid_t    mid_data;
  logic [31:0] temp_w;

  // Coefficient registers; drop bits above each register's width and
  // ignore indexes past the last register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEMP_COEF_ONE:      coef_q.t1  <= cfg_data_i[15:0];
        REG_TEMP_COEF_TWO:      coef_q.t2  <= cfg_data_i[15:0];
        REG_TEMP_COEF_THREE:    coef_q.t3  <= cfg_data_i[15:0];
        REG_HUM_COEF_ONE:       coef_q.c1  <= cfg_data_i[7:0];
        REG_HUM_COEF_TWO:       coef_q.c2  <= cfg_data_i[15:0];
        REG_HUM_COEF_THREE:     coef_q.c3  <= cfg_data_i[7:0];
        REG_HUM_COEF_FOUR_FIVE: coef_q.c45 <= cfg_data_i[23:0];
        REG_HUM_COEF_SIX:       coef_q.c6  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Stages 1-3: fine temperature.
  thc_temp u_temp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .coef_i            (coef_q),
    .valid_i           (in_valid_i),
    .ready_o           (in_ready_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_humidity_i    (raw_humidity_i),
    .valid_o           (fine_valid),
    .ready_i           (fine_ready),
    .data_o            (fine_data)
  );

  // Stages 4-6: temperature output and humidity factors.
  thc_humf u_humf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (coef_q),
    .valid_i (fine_valid),
    .ready_o (fine_ready),
    .data_i  (fine_data),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .data_o  (mid_data)
  );

  // Stages 7-10: humidity product, correction, clamp, output register.
  thc_humb u_humb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (coef_q),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .data_i  (mid_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .temp_o  (temp_w),
    .hum_o   (humidity_fixed_o)
  );

  assign temperature_centi_o = $signed(temp_w);

endmodule

`default_nettype wire

/* rtl/core/thc_temp.sv */
// ----------------------------------------------------------------------------
// thc_temp
// Three-stage fine temperature path: the linear and square products, then
// the quadratic term, then the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module thc_temp
  import thc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire thc_coef_t   coef_i,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [19:0] raw_temperature_i,
  input  wire logic [15:0] raw_humidity_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output thc_fine_t        data_o
);

  logic [2:0]  v_q;
  logic [2:0]  en;
  logic [31:0] t2x, t3x, lin, dlt;
  logic [31:0] p1_d, p1_q, dd_d, dd_q;
  logic [31:0] v1_d, v1_q, pv2_d, pv2_q;
  logic [15:0] h1_q, h2_q;
  thc_fine_t   out_d, out_q;

  // Stage enables ripple back from the consumer.
  assign en[2]   = !v_q[2] || ready_i;
  assign en[1]   = !v_q[1] || en[2];
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];

  always_comb begin
    t2x   = {{16{coef_i.t2[15]}}, coef_i.t2};
    t3x   = {{16{coef_i.t3[15]}}, coef_i.t3};
    lin   = {15'd0, raw_temperature_i[19:3]} - {15'd0, coef_i.t1, 1'b0};
    dlt   = {16'd0, raw_temperature_i[19:4]} - {16'd0, coef_i.t1};
    p1_d  = lin * t2x;
    dd_d  = dlt * dlt;
    v1_d  = asr(p1_q, 11);
    pv2_d = asr(dd_q, 12) * t3x;
    out_d.fine = v1_q + asr(pv2_q, 14);
    out_d.hum  = h2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_q <= p1_d;
      dd_q <= dd_d;
      h1_q <= raw_humidity_i;
    end
    if (en[1]) begin
      v1_q  <= v1_d;
      pv2_q <= pv2_d;
      h2_q  <= h1_q;
    end
    if (en[2]) begin
      out_q <= out_d;
    end
  end

  assign valid_o = v_q[2];
  assign data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/core/thc_humf.sv */
// ----------------------------------------------------------------------------
// thc_humf
// Front of the humidity path: products of the temperature delta, the
// offset term, and the gain term. Also finishes the centi-degree output.
// ----------------------------------------------------------------------------
`default_nettype none

module thc_humf
  import thc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire thc_coef_t coef_i,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire thc_fine_t data_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output thc_mid_t       data_o
);

  logic [2:0]  v_q;
  logic [2:0]  en;
  logic [31:0] c2x, c3x, c4x, c5x, c6x, xd;
  logic [31:0] c5p_d, c5p_q, x6_d, x6_q, x3_d, x3_q, tmp_d;
  logic [31:0] a_d, b0_d, b0_q, b2_d;
  logic [31:0] t4_q, t5_q, a5_q;
  logic [15:0] h4_q;
  thc_mid_t    out_q;

  assign en[2]   = !v_q[2] || ready_i;
  assign en[1]   = !v_q[1] || en[2];
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];

  always_comb begin
    c2x   = {{16{coef_i.c2[15]}}, coef_i.c2};
    c3x   = {24'd0, coef_i.c3};
    c4x   = {{20{coef_i.c45[11]}}, coef_i.c45[11:0]};
    c5x   = {{20{coef_i.c45[23]}}, coef_i.c45[23:12]};
    c6x   = {{24{coef_i.c6[7]}}, coef_i.c6};
    xd    = data_i.fine - FINE_OFFSET;
    c5p_d = c5x * xd;
    x6_d  = xd * c6x;
    x3_d  = xd * c3x;
    tmp_d = asr({data_i.fine[29:0], 2'b00} + data_i.fine + TEMP_ROUND, 8);
    a_d   = asr({2'd0, h4_q, 14'd0} - {c4x[11:0], 20'd0} - c5p_q + HUM_A_ROUND, 15);
    b0_d  = asr(x6_q, 10) * (asr(x3_q, 11) + HUM_X3_BIAS);
    b2_d  = (asr(b0_q, 10) + HUM_B_BIAS) * c2x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c5p_q <= c5p_d;
      x6_q  <= x6_d;
      x3_q  <= x3_d;
      t4_q  <= tmp_d;
      h4_q  <= data_i.hum;
    end
    if (en[1]) begin
      a5_q <= a_d;
      b0_q <= b0_d;
      t5_q <= t4_q;
    end
    if (en[2]) begin
      out_q.a    <= a5_q;
      out_q.b2   <= b2_d;
      out_q.temp <= t5_q;
    end
  end

  assign valid_o = v_q[2];
  assign data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/core/thc_humb.sv */
// ----------------------------------------------------------------------------
// thc_humb
// Back of the humidity path: gain product, second-order correction and
// the final clamp into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module thc_humb
  import thc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire thc_coef_t   coef_i,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire thc_mid_t    data_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [31:0]      temp_o,
  output logic [16:0]      hum_o
);

  logic [3:0]  v_q;
  logic [3:0]  en;
  logic [31:0] x2_d, x2_q, x2b_q, x2c_q;
  logic [31:0] ss_d, ss_q, cor_d, cor_q, x3;
  logic [31:0] s;
  logic [31:0] t7_q, t8_q, t9_q, temp_q;
  logic [16:0] hum_d, hum_q;

  assign en[3]   = !v_q[3] || ready_i;
  assign en[2]   = !v_q[2] || en[3];
  assign en[1]   = !v_q[1] || en[2];
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];

  always_comb begin
    x2_d  = data_i.a * asr(data_i.b2 + HUM_B_ROUND, 14);
    s     = asr(x2_q, 15);
    ss_d  = s * s;
    cor_d = asr(ss_q, 7) * {24'd0, coef_i.c1};
    x3    = x2c_q - asr(cor_q, 4);
    // Clamp to 0..100 %RH on the Q10.22 value, then drop to Q7.10.
    if (x3[31]) begin
      hum_d = '0;
    end else if (x3 > HUM_MAX_Q22) begin
      hum_d = HUM_FIXED_MAX;
    end else begin
      hum_d = x3[28:12];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x2_q <= x2_d;
      t7_q <= data_i.temp;
    end
    if (en[1]) begin
      ss_q  <= ss_d;
      x2b_q <= x2_q;
      t8_q  <= t7_q;
    end
    if (en[2]) begin
      cor_q <= cor_d;
      x2c_q <= x2b_q;
      t9_q  <= t8_q;
    end
    if (en[3]) begin
      hum_q  <= hum_d;
      temp_q <= t9_q;
    end
  end

  assign valid_o = v_q[3];
  assign temp_o  = temp_q;
  assign hum_o   = hum_q;

endmodule

`default_nettype wire

/* rtl/core/thc_checker.sv */
// ----------------------------------------------------------------------------
// thc_checker
// Port-level checks of the compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module thc_checker
  import thc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic signed [31:0]  temperature_centi_o,
  input wire logic [16:0]         humidity_fixed_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(temperature_centi_o)
                                    && $stable(humidity_fixed_o))
    else $error("stalled result changed");

  // A free output slot lets the whole pipeline advance.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with room downstream");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_fixed_o <= HUM_FIXED_MAX)
    else $error("humidity outside clamp range");

  // An accepted transaction must not be lost before it reaches the output.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 !out_valid_o && !in_valid_i |=> !($past(in_valid_i, 10)
      && $past(in_ready_o, 10)) || out_valid_o)
    else $error("accepted transaction never surfaced");

endmodule

bind temp_humidity_compensation thc_checker u_thc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .temperature_centi_o (temperature_centi_o),
  .humidity_fixed_o    (humidity_fixed_o)
);

`default_nettype wire
